>>> rtl/core/upd_pkg.sv
// Shared constants, types and character helpers for the URL percent decoder.
package upd_pkg;

	// Character codes used by the escape decoder.
	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_UA    = 8'h41;
	localparam logic [7:0] CHAR_UF    = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LF    = 8'h66;
	localparam logic [7:0] LOW_NIBBLE = 8'h0f;
	localparam logic [7:0] ALPHA_OFS  = 8'd9;

	// Result queue sizing: one item may produce up to three results.
	localparam int MAX_RES    = 3;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// What the decoder currently holds of a pending escape.
	typedef enum logic [2:0] {
		HELD_NONE  = 3'b001,
		HELD_PCT   = 3'b010,
		HELD_DIGIT = 3'b100
	} held_t;

	// Results produced by one item: count, end-of-string flag and bytes in order.
	typedef struct packed {
		logic [1:0] n;
		logic       last;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} res_t;

	// True for a hex digit character of either case.
	function automatic logic is_hex(input logic [7:0] c);
		return ((c >= CHAR_0) && (c <= CHAR_9)) ||
		       ((c >= CHAR_UA) && (c <= CHAR_UF)) ||
		       ((c >= CHAR_LA) && (c <= CHAR_LF));
	endfunction

	// Value of a hex digit character.
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if ((c >= CHAR_0) && (c <= CHAR_9)) begin
			v = c - CHAR_0;
		end else begin
			v = (c & LOW_NIBBLE) + ALPHA_OFS;
		end
		return v[3:0];
	endfunction

endpackage

>>> rtl/core/upd_decode.sv
// Escape decoder: held escape state and the per-item result logic.
module upd_decode
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s1,
	input  logic [7:0] byte_s1,
	input  logic       last_s1,
	output res_t       res
);

	held_t      held_q, held_d;
	logic [7:0] digit_q, digit_d;
	logic       b_hex;
	logic       do_fresh;
	logic [1:0] pre_n;

	assign b_hex = is_hex(byte_s1);

	// Work out the results of the registered item and the next held state.
	always_comb begin
		res      = '0;
		held_d   = held_q;
		digit_d  = digit_q;
		do_fresh = 1'b0;
		pre_n    = 2'd0;
		if (valid_s1) begin
			held_d = HELD_NONE;
			unique case (held_q)
				HELD_PCT: begin
					if (b_hex && !last_s1) begin
						held_d  = HELD_DIGIT;
						digit_d = byte_s1;
					end else begin
						pre_n    = 2'd1;
						do_fresh = 1'b1;
					end
				end
				HELD_DIGIT: begin
					if (b_hex) begin
						res.n  = 2'd1;
						res.b0 = {hex_val(digit_q), hex_val(byte_s1)};
					end else begin
						pre_n    = 2'd2;
						do_fresh = 1'b1;
					end
				end
				default: begin
					do_fresh = 1'b1;
				end
			endcase

			// A broken escape emits the held characters before the new byte.
			if (do_fresh) begin
				res.b0 = (pre_n == 2'd0) ? byte_s1 : PCT_CHAR;
				res.b1 = (pre_n == 2'd1) ? byte_s1 : digit_q;
				res.b2 = byte_s1;
				if ((byte_s1 == PCT_CHAR) && !last_s1) begin
					held_d = HELD_PCT;
					res.n  = pre_n;
				end else begin
					res.n = pre_n + 2'd1;
				end
			end

			// The end of the string flushes and clears the held state.
			if (last_s1) begin
				held_d   = HELD_NONE;
				digit_d  = '0;
				res.last = 1'b1;
			end
		end
	end

	// Held escape state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= HELD_NONE;
			digit_q <= '0;
		end else begin
			held_q  <= held_d;
			digit_q <= digit_d;
		end
	end

endmodule

>>> rtl/core/upd_out_fifo.sv
// Result queue: takes up to three results per cycle and releases one per cycle when popped.
module upd_out_fifo
	import upd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  res_t             wr,
	input  logic             pop,
	output logic             rd_valid,
	output logic [7:0]       rd_byte,
	output logic             rd_last,
	output logic [CNT_W-1:0] count
);

	logic [8:0]         mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW-1:0] wr_ptr_p1, wr_ptr_p2;
	logic [CNT_W-1:0]   count_q;

	assign wr_ptr_p1 = wr_ptr_q + FIFO_AW'(1);
	assign wr_ptr_p2 = wr_ptr_q + FIFO_AW'(2);

	// Store the results in order; the end flag goes on the final one.
	always_ff @(posedge clk) begin
		if (wr.n > 2'd0) begin
			mem_q[wr_ptr_q] <= {wr.last && (wr.n == 2'd1), wr.b0};
		end
		if (wr.n > 2'd1) begin
			mem_q[wr_ptr_p1] <= {wr.last && (wr.n == 2'd2), wr.b1};
		end
		if (wr.n > 2'd2) begin
			mem_q[wr_ptr_p2] <= {wr.last, wr.b2};
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(wr.n);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + CNT_W'(wr.n) - CNT_W'(pop);
		end
	end

	assign rd_valid           = (count_q != '0);
	assign {rd_last, rd_byte} = mem_q[rd_ptr_q];
	assign count              = count_q;

endmodule

>>> rtl/core/url_percent_decoder.sv
// Path: an accepted item passes the input stage register and the result queue.
// Throughput: one item per cycle in and one result per cycle out while out_stall
// is low; the input is stalled only when the 16-entry result queue cannot be
// sure of room for three more results from the registered item and the next one.
// Reset: arst_n clears the held escape, the input stage and the queue at once.
// Top level of the streaming URL percent decoder.
module url_percent_decoder
	import upd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;
	res_t             res;
	logic [CNT_W-1:0] count;
	logic [CNT_W:0]   need;
	logic             in_acc;
	logic             pop;

	// Room check: queue fill plus worst case of the staged and the new item.
	assign need     = (CNT_W+1)'(count) +
	                  (valid_s1 ? (CNT_W+1)'(MAX_RES) : '0) +
	                  (CNT_W+1)'(MAX_RES);
	assign in_stall = (need > (CNT_W+1)'(FIFO_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign pop      = out_valid && !out_stall;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	upd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.last_s1  (last_s1),
		.res      (res)
	);

	upd_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res),
		.pop      (pop),
		.rd_valid (out_valid),
		.rd_byte  (out_byte),
		.rd_last  (out_last),
		.count    (count)
	);

endmodule

>>> rtl/core/upd_checker.sv
// Port-level checks for the URL percent decoder and their binding.
module upd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled result changed");

	// The final byte of a string always yields a result after the input stage and the queue.
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_last |-> ##2 out_valid)
		else $error("no result after end of string");

	// With the result queue empty the input is never stalled.
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while queue empty");

	// A result appears only as a consequence of an accepted item.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without an accepted item");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
